// ===== design/quaternary_heap_timer_queue_core_macros.svh =====
// Assertion macros for the timer queue core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef QUATERNARY_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
`define QUATERNARY_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
// same-cycle implication
`define QHTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define QHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/qhtq_pkg.sv =====
// Shared types, codes and defaults of the four-ary heap timer queue.
// No dependencies.
package qhtq_pkg;
    localparam int QHTQ_CAPACITY = 64;
    localparam int QHTQ_ID_BITS  = 16;

    localparam logic [1:0] K_START  = 2'd0;
    localparam logic [1:0] K_CANCEL = 2'd1;
    localparam logic [1:0] K_TICK   = 2'd2;

    // datapath micro-operations
    localparam logic [3:0] U_NOP    = 4'd0;
    localparam logic [3:0] U_CAP    = 4'd1;
    localparam logic [3:0] U_INS    = 4'd2;
    localparam logic [3:0] U_UP_RD  = 4'd3;
    localparam logic [3:0] U_UP_MV  = 4'd4;
    localparam logic [3:0] U_PUT    = 4'd5;
    localparam logic [3:0] U_DN_RD0 = 4'd6;
    localparam logic [3:0] U_DN_RD1 = 4'd7;
    localparam logic [3:0] U_DN_MV  = 4'd8;
    localparam logic [3:0] U_SC_RD  = 4'd9;
    localparam logic [3:0] U_SC_NX  = 4'd10;
    localparam logic [3:0] U_SC_H0  = 4'd11;
    localparam logic [3:0] U_SC_H1  = 4'd12;
    localparam logic [3:0] U_RM_RD  = 4'd13;
    localparam logic [3:0] U_RM_LD  = 4'd14;
    localparam logic [3:0] U_TK_POP = 4'd15;

    // result codes
    localparam logic [2:0] E_START_OK   = 3'd0;
    localparam logic [2:0] E_START_FULL = 3'd1;
    localparam logic [2:0] E_CAN_OK     = 3'd2;
    localparam logic [2:0] E_CAN_NO     = 3'd3;
    localparam logic [2:0] E_TK_MID     = 3'd4;
    localparam logic [2:0] E_TK_LAST    = 3'd5;
    localparam logic [2:0] E_TK_NONE    = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] delay_ms;
        logic [62:0] now;
        logic [15:0] cancel_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tmr_id;
        logic        ok;
        logic        fired;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [63:0] dl;
        logic [15:0] id;
    } t_entry;

    typedef struct packed {
        logic [3:0] uop;
        logic       tk_rd;
        logic       emit;
        logic [2:0] ecode;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       n_zero;
        logic       up_root;
        logic       up_stop;
        logic       moved;
        logic       dn_leaf;
        logic       dn_stop;
        logic       sc_end;
        logic       sc_hit0;
        logic       sc_hit1;
        logic       rm_last;
        logic       due;
        logic       pend_v;
        logic       out_free;
    } t_stat;
endpackage

// ===== design/qhtq_ctrl.sv =====
// Sequencer of the timer queue: steps the datapath through each operation.
// Depends on qhtq_pkg.
module qhtq_ctrl import qhtq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_UP    = 4'd2;
    localparam logic [3:0] S_UP_CK = 4'd3;
    localparam logic [3:0] S_UPFIN = 4'd4;
    localparam logic [3:0] S_DN    = 4'd5;
    localparam logic [3:0] S_DN1   = 4'd6;
    localparam logic [3:0] S_DN_CK = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_SC_RD = 4'd9;
    localparam logic [3:0] S_SC_CK = 4'd10;
    localparam logic [3:0] S_RM    = 4'd11;
    localparam logic [3:0] S_RM_LD = 4'd12;
    localparam logic [3:0] S_TK_RD = 4'd13;
    localparam logic [3:0] S_TK_CK = 4'd14;
    localparam logic [3:0] S_EMIT  = 4'd15;

    logic [3:0] r_state, n_state;
    logic [2:0] r_ecode, n_ecode;
    logic       r_rem, n_rem;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ecode = r_ecode;
        n_rem   = r_rem;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = U_CAP;
                    n_rem     = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    K_START: begin
                        if (i_stat.full) begin
                            n_ecode = E_START_FULL;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.uop = U_INS;
                            n_state   = S_UP;
                        end
                    end
                    K_CANCEL: n_state = S_SC_RD;
                    K_TICK:   n_state = S_TK_RD;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_UP: begin
                if (i_stat.up_root) begin
                    n_state = S_UPFIN;
                end else begin
                    o_cmd.uop = U_UP_RD;
                    n_state   = S_UP_CK;
                end
            end
            S_UP_CK: begin
                if (i_stat.up_stop) begin
                    n_state = S_UPFIN;
                end else begin
                    o_cmd.uop = U_UP_MV;
                    n_state   = S_UP;
                end
            end
            S_UPFIN: begin
                // an entry that climbed cannot sink
                if (r_rem && !i_stat.moved) begin
                    n_state = S_DN;
                end else begin
                    o_cmd.uop = U_PUT;
                    n_state   = S_DONE;
                end
            end
            S_DN: begin
                if (i_stat.dn_leaf) begin
                    o_cmd.uop = U_PUT;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.uop = U_DN_RD0;
                    n_state   = S_DN1;
                end
            end
            S_DN1: begin
                o_cmd.uop = U_DN_RD1;
                n_state   = S_DN_CK;
            end
            S_DN_CK: begin
                if (i_stat.dn_stop) begin
                    o_cmd.uop = U_PUT;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.uop = U_DN_MV;
                    n_state   = S_DN;
                end
            end
            S_DONE: begin
                case (i_stat.op)
                    K_START: begin
                        n_ecode = E_START_OK;
                        n_state = S_EMIT;
                    end
                    K_CANCEL: begin
                        n_ecode = E_CAN_OK;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_TK_RD;
                endcase
            end
            S_SC_RD: begin
                if (i_stat.sc_end) begin
                    n_ecode = E_CAN_NO;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.uop = U_SC_RD;
                    n_state   = S_SC_CK;
                end
            end
            S_SC_CK: begin
                if (i_stat.sc_hit0) begin
                    o_cmd.uop = U_SC_H0;
                    n_state   = S_RM;
                end else if (i_stat.sc_hit1) begin
                    o_cmd.uop = U_SC_H1;
                    n_state   = S_RM;
                end else begin
                    o_cmd.uop = U_SC_NX;
                    n_state   = S_SC_RD;
                end
            end
            S_RM: begin
                o_cmd.uop = U_RM_RD;
                n_state   = i_stat.rm_last ? S_DONE : S_RM_LD;
            end
            S_RM_LD: begin
                o_cmd.uop = U_RM_LD;
                n_rem     = 1'b1;
                n_state   = S_UP;
            end
            S_TK_RD: begin
                if (i_stat.n_zero) begin
                    n_ecode = i_stat.pend_v ? E_TK_LAST : E_TK_NONE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.tk_rd = 1'b1;
                    n_state     = S_TK_CK;
                end
            end
            S_TK_CK: begin
                if (!i_stat.due) begin
                    n_ecode = i_stat.pend_v ? E_TK_LAST : E_TK_NONE;
                    n_state = S_EMIT;
                end else if (!i_stat.pend_v || i_stat.out_free) begin
                    // release the previous fired item, hold the new one
                    o_cmd.emit  = i_stat.pend_v;
                    o_cmd.ecode = E_TK_MID;
                    o_cmd.uop   = U_TK_POP;
                    n_state     = S_RM;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.ecode = r_ecode;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecode <= E_START_OK;
            r_rem   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecode <= n_ecode;
            r_rem   <= n_rem;
        end
    end
endmodule

// ===== design/qhtq_dpath.sv =====
// Datapath of the timer queue: heap memory, sift registers, id counter, result register.
// Depends on qhtq_pkg.
module qhtq_dpath import qhtq_pkg::*; #(
    parameter int CAPACITY = QHTQ_CAPACITY,
    parameter int ID_BITS  = QHTQ_ID_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_stat o_stat,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_out o_out
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = IDX_W + 3;
    localparam int CTR_W = (ID_BITS < 16) ? ID_BITS : 16;

    t_entry r_mem [CAPACITY];
    t_entry r_rd0, r_rd1;

    t_in              r_in;
    t_entry           r_cur;
    logic [IDX_W-1:0] r_pos;
    logic [CNT_W-1:0] r_n;
    logic [CTR_W-1:0] r_idc;
    logic             r_moved;
    logic [CNT_W:0]   r_si;
    t_entry           r_best_e;
    logic [IDX_W-1:0] r_best_i;
    logic             r_pend_v;
    logic [15:0]      r_pend_id;
    logic             r_ov;
    t_out             r_out;

    logic [IDX_W-1:0] pm1, parent;
    logic [CW-1:0]    c0, c1, c2, c3, ncw;
    logic [CNT_W:0]   si1;
    logic [CNT_W-1:0] nm1;
    logic [CTR_W-1:0] nid;
    t_entry           fin_e;
    logic [IDX_W-1:0] fin_i;
    logic             out_free;

    logic             rd_en, we;
    logic [IDX_W-1:0] ra0, ra1, wa;
    t_entry           wd;
    t_out             ev;

    assign pm1    = r_pos - 1'b1;
    assign parent = pm1 >> 2;
    assign c0     = {1'b0, r_pos, 2'b00} + CW'(1);
    assign c1     = c0 + CW'(1);
    assign c2     = c0 + CW'(2);
    assign c3     = c0 + CW'(3);
    assign ncw    = CW'(r_n);
    assign si1    = r_si + 1'b1;
    assign nm1    = r_n - 1'b1;
    assign nid    = r_idc + 1'b1;
    assign out_free = !r_ov || !i_out_stall;

    // merge the second child pair into the best of the first; earliest minimum wins
    always_comb begin
        fin_e = r_best_e;
        fin_i = r_best_i;
        if (c2 < ncw && r_rd0.dl < fin_e.dl) begin
            fin_e = r_rd0;
            fin_i = c2[IDX_W-1:0];
        end
        if (c3 < ncw && r_rd1.dl < fin_e.dl) begin
            fin_e = r_rd1;
            fin_i = c3[IDX_W-1:0];
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_in.func;
        o_stat.full     = (r_n == CNT_W'(CAPACITY));
        o_stat.n_zero   = (r_n == '0);
        o_stat.up_root  = (r_pos == '0);
        o_stat.up_stop  = (r_cur.dl >= r_rd0.dl);
        o_stat.moved    = r_moved;
        o_stat.dn_leaf  = (c0 >= ncw);
        o_stat.dn_stop  = (fin_e.dl >= r_cur.dl);
        o_stat.sc_end   = (r_si >= {1'b0, r_n});
        o_stat.sc_hit0  = (r_si < {1'b0, r_n}) && (r_rd0.id == r_in.cancel_id);
        o_stat.sc_hit1  = (si1 < {1'b0, r_n}) && (r_rd1.id == r_in.cancel_id);
        o_stat.rm_last  = (CNT_W'(r_pos) == nm1);
        o_stat.due      = (64'(r_in.now) >= r_rd0.dl);
        o_stat.pend_v   = r_pend_v;
        o_stat.out_free = out_free;
    end

    always_comb begin
        rd_en = i_cmd.tk_rd;
        ra0   = '0;
        ra1   = '0;
        we    = 1'b0;
        wa    = r_pos;
        wd    = r_cur;
        case (i_cmd.uop)
            U_UP_RD: begin
                rd_en = 1'b1;
                ra0   = parent;
            end
            U_UP_MV: begin
                we = 1'b1;
                wd = r_rd0;
            end
            U_PUT: we = 1'b1;
            U_DN_RD0: begin
                rd_en = 1'b1;
                ra0   = c0[IDX_W-1:0];
                ra1   = c1[IDX_W-1:0];
            end
            U_DN_RD1: begin
                rd_en = 1'b1;
                ra0   = c2[IDX_W-1:0];
                ra1   = c3[IDX_W-1:0];
            end
            U_DN_MV: begin
                we = 1'b1;
                wd = fin_e;
            end
            U_SC_RD: begin
                rd_en = 1'b1;
                ra0   = r_si[IDX_W-1:0];
                ra1   = si1[IDX_W-1:0];
            end
            U_RM_RD: begin
                rd_en = 1'b1;
                ra0   = nm1[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd0 <= r_mem[ra0];
            r_rd1 <= r_mem[ra1];
        end
    end

    always_comb begin
        ev = '0;
        case (i_cmd.ecode)
            E_START_OK: begin
                ev.kind   = K_START;
                ev.tmr_id = 16'(r_idc);
                ev.ok     = 1'b1;
                ev.last   = 1'b1;
            end
            E_START_FULL: begin
                ev.kind = K_START;
                ev.last = 1'b1;
            end
            E_CAN_OK: begin
                ev.kind   = K_CANCEL;
                ev.tmr_id = r_in.cancel_id;
                ev.ok     = 1'b1;
                ev.last   = 1'b1;
            end
            E_CAN_NO: begin
                ev.kind   = K_CANCEL;
                ev.tmr_id = r_in.cancel_id;
                ev.last   = 1'b1;
            end
            E_TK_MID: begin
                ev.kind   = K_TICK;
                ev.tmr_id = r_pend_id;
                ev.ok     = 1'b1;
                ev.fired  = 1'b1;
            end
            E_TK_LAST: begin
                ev.kind   = K_TICK;
                ev.tmr_id = r_pend_id;
                ev.ok     = 1'b1;
                ev.fired  = 1'b1;
                ev.last   = 1'b1;
            end
            default: begin
                ev.kind = K_TICK;
                ev.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_idc    <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_moved  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_ov  <= 1'b1;
                r_out <= ev;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.uop)
                U_CAP: begin
                    r_in     <= i_in;
                    r_si     <= '0;
                    r_pend_v <= 1'b0;
                    r_moved  <= 1'b0;
                end
                U_INS: begin
                    r_cur.dl <= 64'(r_in.now) + 64'(r_in.delay_ms);
                    r_cur.id <= 16'(nid);
                    r_idc    <= nid;
                    r_pos    <= r_n[IDX_W-1:0];
                    r_n      <= r_n + 1'b1;
                end
                U_UP_MV: begin
                    r_pos   <= parent;
                    r_moved <= 1'b1;
                end
                U_DN_RD1: begin
                    if (c1 < ncw && r_rd1.dl < r_rd0.dl) begin
                        r_best_e <= r_rd1;
                        r_best_i <= c1[IDX_W-1:0];
                    end else begin
                        r_best_e <= r_rd0;
                        r_best_i <= c0[IDX_W-1:0];
                    end
                end
                U_DN_MV: r_pos <= fin_i;
                U_SC_NX: r_si <= r_si + 2'd2;
                U_SC_H0: r_pos <= r_si[IDX_W-1:0];
                U_SC_H1: r_pos <= si1[IDX_W-1:0];
                U_RM_RD: r_n <= nm1;
                U_RM_LD: begin
                    r_cur   <= r_rd0;
                    r_moved <= 1'b0;
                end
                U_TK_POP: begin
                    r_pend_v  <= 1'b1;
                    r_pend_id <= r_rd0.id;
                    r_pos     <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;
endmodule

// ===== design/quaternary_heap_timer_queue_core.sv =====
// Timer queue on a four-ary min-heap. Start appends the new timer and sifts it up,
// comparing it with one parent after another up to the root; cancel scans two slots at a
// time, then on a hit moves the last entry into the hole and sifts it up, else down.
// Tick pops each fired timer and sinks the moved last entry level by level, until a check finds none due.
// One item at a time: a new item is taken in the idle cycle after the last result is queued.
// Synchronous active-low reset empties the heap and zeroes the id counter at once.
module quaternary_heap_timer_queue_core import qhtq_pkg::*; #(
    parameter int CAPACITY = QHTQ_CAPACITY,
    parameter int ID_BITS  = QHTQ_ID_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);
    `include "quaternary_heap_timer_queue_core_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    qhtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qhtq_dpath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    `QHTQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "idle after item")
    `QHTQ_ASSERT_NOW(a_fired_is_tick, o_out_valid && o_out.fired, o_out.kind == K_TICK, "bad fire")
    `QHTQ_ASSERT_NOW(a_single_last, o_out_valid && o_out.kind != K_TICK, o_out.last, "not last")
    `QHTQ_ASSERT_NOW(a_emit_room, cmd.emit, stat.out_free, "result emitted into full register")
endmodule
